// ----- sv/delayed_event_pulse_timer_unit_macros.svh -----
// Assertion macros shared by the verification files of the timer unit.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef DELAYED_EVENT_PULSE_TIMER_UNIT_MACROS_SVH
`define DELAYED_EVENT_PULSE_TIMER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DEPT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DEPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/dept_pkg.sv -----
// Shared types and constants for the delayed event pulse timer unit.
// No dependencies; every other file but the macro header refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package dept_pkg;

  // Width of the timing fields on the ports and default counter width.
  localparam int FIELD_W     = 32;
  localparam int TIME_W_DEF  = 32;

  typedef enum logic [2:0] {
    PH_NONE     = 3'd0,
    PH_WAIT_ON  = 3'd1,
    PH_ON       = 3'd2,
    PH_WAIT_OFF = 3'd3,
    PH_OFF      = 3'd4
  } phase_t;

  // Command codes carried by in_command.
  localparam logic [2:0] CMD_TICK       = 3'd0;
  localparam logic [2:0] CMD_ON         = 3'd1;
  localparam logic [2:0] CMD_OFF        = 3'd2;
  localparam logic [2:0] CMD_CLR_PHASE  = 3'd3;
  localparam logic [2:0] CMD_ON_DELAY   = 3'd4;
  localparam logic [2:0] CMD_OFF_DELAY  = 3'd5;

  // Output modes.
  localparam logic [2:0] TY_NORMAL    = 3'd0;
  localparam logic [2:0] TY_PULSE     = 3'd1;
  localparam logic [2:0] TY_PULSE_OFF = 3'd2;
  localparam logic [2:0] TY_PULSE2    = 3'd3;
  localparam logic [2:0] TY_PWM       = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] REG_ON_DELAY  = 3'd0;
  localparam logic [2:0] REG_OFF_DELAY = 3'd1;
  localparam logic [2:0] REG_EV_TYPE   = 3'd2;
  localparam logic [2:0] REG_PULSE_ON  = 3'd3;
  localparam logic [2:0] REG_PULSE_OFF = 3'd4;

  // Status produced by one item.
  typedef struct packed {
    phase_t phase;
    logic   level;
    logic   sw_on;
    logic   sw_off;
    logic   changed;
  } res_t;

endpackage

`default_nettype wire

// ----- sv/dept_clamp.sv -----
// Saturates a 32-bit time value to the counter width of the timer unit.
// Depends on dept_pkg for the field width.
`timescale 1ns / 1ps
`default_nettype none

module dept_clamp #(
  parameter int TIME_WIDTH = dept_pkg::TIME_W_DEF
) (
  input  wire logic [dept_pkg::FIELD_W-1:0] value_in,
  output logic      [TIME_WIDTH-1:0]        value_out
);

  localparam int WideW = (TIME_WIDTH > dept_pkg::FIELD_W) ? TIME_WIDTH : dept_pkg::FIELD_W;

  logic [WideW-1:0] wide_val;
  logic [WideW-1:0] tmax;

  assign wide_val  = WideW'(value_in);
  assign tmax      = WideW'({TIME_WIDTH{1'b1}});
  assign value_out = (wide_val > tmax) ? {TIME_WIDTH{1'b1}} : wide_val[TIME_WIDTH-1:0];

endmodule

`default_nettype wire

// ----- sv/dept_cfg.sv -----
// Configuration registers and active delays of the timer unit.
// Depends on dept_pkg and dept_clamp.
`timescale 1ns / 1ps
`default_nettype none

module dept_cfg #(
  parameter int TIME_WIDTH = dept_pkg::TIME_W_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [2:0]                    cfg_index,
  input  wire logic [dept_pkg::FIELD_W-1:0]  cfg_data,
  input  wire logic                          ld_on,
  input  wire logic                          ld_off,
  input  wire logic [TIME_WIDTH-1:0]         ld_value,
  output logic      [2:0]                    event_type,
  output logic      [TIME_WIDTH-1:0]         on_dly,
  output logic      [TIME_WIDTH-1:0]         off_dly,
  output logic      [TIME_WIDTH-1:0]         pulse_on,
  output logic      [TIME_WIDTH-1:0]         pulse_off
);

  logic [TIME_WIDTH-1:0] data_clamped;
  logic [2:0]            event_type_r;
  logic [TIME_WIDTH-1:0] on_dly_r;
  logic [TIME_WIDTH-1:0] off_dly_r;
  logic [TIME_WIDTH-1:0] pulse_on_r;
  logic [TIME_WIDTH-1:0] pulse_off_r;

  dept_clamp #(.TIME_WIDTH(TIME_WIDTH)) u_clamp (
    .value_in  (cfg_data),
    .value_out (data_clamped)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      event_type_r <= dept_pkg::TY_NORMAL;
      on_dly_r     <= '0;
      off_dly_r    <= '0;
      pulse_on_r   <= '0;
      pulse_off_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        dept_pkg::REG_ON_DELAY:  on_dly_r     <= data_clamped;
        dept_pkg::REG_OFF_DELAY: off_dly_r    <= data_clamped;
        dept_pkg::REG_EV_TYPE:   event_type_r <= cfg_data[2:0];
        dept_pkg::REG_PULSE_ON:  pulse_on_r   <= data_clamped;
        dept_pkg::REG_PULSE_OFF: pulse_off_r  <= data_clamped;
        default: ;
      endcase
    end else begin
      // The delay-carrying commands replace the active delay.
      if (ld_on) begin
        on_dly_r <= ld_value;
      end
      if (ld_off) begin
        off_dly_r <= ld_value;
      end
    end
  end

  assign event_type = event_type_r;
  assign on_dly     = on_dly_r;
  assign off_dly    = off_dly_r;
  assign pulse_on   = pulse_on_r;
  assign pulse_off  = pulse_off_r;

endmodule

`default_nettype wire

// ----- sv/dept_step.sv -----
// Next-state logic of the timer unit: applies one tick or command to the state.
// Depends on dept_pkg; purely combinational.
`timescale 1ns / 1ps
`default_nettype none

module dept_step #(
  parameter int TIME_WIDTH = dept_pkg::TIME_W_DEF
) (
  input  wire logic [2:0]            cmd,
  input  wire logic [TIME_WIDTH-1:0] dly,
  input  wire dept_pkg::phase_t      phase,
  input  wire dept_pkg::phase_t      last_phase,
  input  wire logic                  level,
  input  wire logic [TIME_WIDTH-1:0] since_on,
  input  wire logic [TIME_WIDTH-1:0] since_off,
  input  wire logic [2:0]            event_type,
  input  wire logic [TIME_WIDTH-1:0] on_dly,
  input  wire logic [TIME_WIDTH-1:0] off_dly,
  input  wire logic [TIME_WIDTH-1:0] pulse_on,
  input  wire logic [TIME_WIDTH-1:0] pulse_off,
  output dept_pkg::res_t             res,
  output dept_pkg::phase_t           last_phase_nxt,
  output logic [TIME_WIDTH-1:0]      since_on_nxt,
  output logic [TIME_WIDTH-1:0]      since_off_nxt,
  output logic                       ld_on,
  output logic                       ld_off
);

  logic                  pulsed;
  logic                  after_off;
  logic                  is_pwm;
  logic [TIME_WIDTH-1:0] son_inc;
  logic [TIME_WIDTH-1:0] soff_inc;
  logic [TIME_WIDTH-1:0] on_eff;
  logic [TIME_WIDTH-1:0] off_eff;

  assign pulsed    = (event_type == dept_pkg::TY_PULSE) || (event_type == dept_pkg::TY_PULSE2) ||
                     (event_type == dept_pkg::TY_PWM);
  assign after_off = (event_type == dept_pkg::TY_PULSE_OFF) ||
                     (event_type == dept_pkg::TY_PULSE2);
  assign is_pwm    = (event_type == dept_pkg::TY_PWM);

  // Elapsed counters stick at all ones.
  assign son_inc  = (&since_on)  ? since_on  : since_on  + TIME_WIDTH'(1);
  assign soff_inc = (&since_off) ? since_off : since_off + TIME_WIDTH'(1);

  assign on_eff  = (cmd == dept_pkg::CMD_ON_DELAY)  ? dly : on_dly;
  assign off_eff = (cmd == dept_pkg::CMD_OFF_DELAY) ? dly : off_dly;
  assign ld_on   = (cmd == dept_pkg::CMD_ON_DELAY);
  assign ld_off  = (cmd == dept_pkg::CMD_OFF_DELAY);

  always_comb begin
    res.phase      = phase;
    res.level      = level;
    res.sw_on      = 1'b0;
    res.sw_off     = 1'b0;
    res.changed    = 1'b0;
    last_phase_nxt = last_phase;
    since_on_nxt   = since_on;
    since_off_nxt  = since_off;

    case (cmd)
      dept_pkg::CMD_TICK: begin
        since_on_nxt  = son_inc;
        since_off_nxt = soff_inc;
        case (phase)
          dept_pkg::PH_WAIT_ON: begin
            if (son_inc > on_dly) begin
              res.phase    = dept_pkg::PH_ON;
              since_on_nxt = '0;
              res.sw_on    = 1'b1;
              res.level    = 1'b1;
            end
          end
          dept_pkg::PH_WAIT_OFF: begin
            if (soff_inc > off_dly) begin
              res.phase     = dept_pkg::PH_OFF;
              since_off_nxt = '0;
              res.sw_off    = level;
              res.level     = 1'b0;
            end
          end
          dept_pkg::PH_ON: begin
            if (pulsed && level && (son_inc > pulse_on)) begin
              since_on_nxt = '0;
              res.sw_off   = 1'b1;
              res.level    = 1'b0;
            end else if (is_pwm && !level && (son_inc > pulse_off)) begin
              since_on_nxt = '0;
              res.sw_on    = 1'b1;
              res.level    = 1'b1;
            end
          end
          dept_pkg::PH_OFF: begin
            // The after-off pulse rises on the next tick and keeps repeating.
            if (after_off && !level) begin
              since_on_nxt = '0;
              res.sw_on    = 1'b1;
              res.level    = 1'b1;
            end else if (after_off && level && (son_inc > pulse_on)) begin
              since_on_nxt = '0;
              res.sw_off   = 1'b1;
              res.level    = 1'b0;
            end
          end
          default: ;
        endcase
        if (res.phase != last_phase) begin
          res.changed    = 1'b1;
          last_phase_nxt = res.phase;
        end
      end
      dept_pkg::CMD_ON, dept_pkg::CMD_ON_DELAY: begin
        if ((phase != dept_pkg::PH_WAIT_ON) && (phase != dept_pkg::PH_ON)) begin
          since_on_nxt = '0;
          if (on_eff == '0) begin
            res.phase = dept_pkg::PH_ON;
            res.sw_on = 1'b1;
            res.level = 1'b1;
          end else begin
            res.phase = dept_pkg::PH_WAIT_ON;
          end
        end
      end
      dept_pkg::CMD_OFF, dept_pkg::CMD_OFF_DELAY: begin
        if ((phase != dept_pkg::PH_WAIT_OFF) && (phase != dept_pkg::PH_OFF)) begin
          since_off_nxt = '0;
          if (off_eff == '0) begin
            res.phase  = dept_pkg::PH_OFF;
            res.sw_off = level;
            res.level  = 1'b0;
          end else begin
            res.phase = dept_pkg::PH_WAIT_OFF;
          end
        end
      end
      dept_pkg::CMD_CLR_PHASE: begin
        res.phase = dept_pkg::PH_NONE;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/delayed_event_pulse_timer_unit.sv -----
// Top level of the delayed event pulse timer unit.
// Depends on dept_pkg, dept_clamp, dept_cfg and dept_step.
`timescale 1ns / 1ps
`default_nettype none

// The unit takes one tick or command per clock cycle and returns exactly one
// status item for each. An accepted item sits in an input register until the
// output register is free, the state update and status are computed from it in
// a single pass of compares and counter increments, and the status lands in the
// output register, from which it transfers while out_ready is high. Throughput
// is one item per cycle as long as the result side keeps taking transfers;
// in_ready follows out_ready combinationally through the two registers. Delays
// and durations are counted in ticks with TIME_WIDTH-bit saturating counters;
// larger values saturate on load and then never expire. Configuration writes
// are accepted in every cycle and must only be issued while no item is in
// flight.
module delayed_event_pulse_timer_unit #(
  parameter int TIME_WIDTH = dept_pkg::TIME_W_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [2:0]                   in_command,
  input  wire logic [dept_pkg::FIELD_W-1:0] in_delay_value,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic      [2:0]                   out_phase,
  output logic                              out_output_level,
  output logic                              out_switched_on,
  output logic                              out_switched_off,
  output logic                              out_phase_changed,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [2:0]                   cfg_index,
  input  wire logic [dept_pkg::FIELD_W-1:0] cfg_data
);

  logic                  s0_vld_r;
  logic [2:0]            s0_cmd_r;
  logic [TIME_WIDTH-1:0] s0_dly_r;
  logic [TIME_WIDTH-1:0] dly_clamped;
  logic                  out_vld_r;
  dept_pkg::res_t        out_res_r;
  logic                  advance;
  logic                  out_free;

  dept_pkg::phase_t      phase_r;
  dept_pkg::phase_t      last_phase_r;
  logic                  level_r;
  logic [TIME_WIDTH-1:0] since_on_r;
  logic [TIME_WIDTH-1:0] since_off_r;

  dept_pkg::res_t        res_nxt;
  dept_pkg::phase_t      last_phase_nxt;
  logic [TIME_WIDTH-1:0] since_on_nxt;
  logic [TIME_WIDTH-1:0] since_off_nxt;
  logic                  ld_on;
  logic                  ld_off;

  logic [2:0]            event_type;
  logic [TIME_WIDTH-1:0] on_dly;
  logic [TIME_WIDTH-1:0] off_dly;
  logic [TIME_WIDTH-1:0] pulse_on;
  logic [TIME_WIDTH-1:0] pulse_off;

  assign out_free  = !out_vld_r || out_ready;
  assign advance   = s0_vld_r && out_free;
  assign in_ready  = !s0_vld_r || out_free;
  assign cfg_ready = 1'b1;

  dept_clamp #(.TIME_WIDTH(TIME_WIDTH)) u_dly_clamp (
    .value_in  (in_delay_value),
    .value_out (dly_clamped)
  );

  dept_cfg #(.TIME_WIDTH(TIME_WIDTH)) u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .ld_on      (advance && ld_on),
    .ld_off     (advance && ld_off),
    .ld_value   (s0_dly_r),
    .event_type (event_type),
    .on_dly     (on_dly),
    .off_dly    (off_dly),
    .pulse_on   (pulse_on),
    .pulse_off  (pulse_off)
  );

  dept_step #(.TIME_WIDTH(TIME_WIDTH)) u_step (
    .cmd            (s0_cmd_r),
    .dly            (s0_dly_r),
    .phase          (phase_r),
    .last_phase     (last_phase_r),
    .level          (level_r),
    .since_on       (since_on_r),
    .since_off      (since_off_r),
    .event_type     (event_type),
    .on_dly         (on_dly),
    .off_dly        (off_dly),
    .pulse_on       (pulse_on),
    .pulse_off      (pulse_off),
    .res            (res_nxt),
    .last_phase_nxt (last_phase_nxt),
    .since_on_nxt   (since_on_nxt),
    .since_off_nxt  (since_off_nxt),
    .ld_on          (ld_on),
    .ld_off         (ld_off)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (in_ready) begin
      s0_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s0_cmd_r <= in_command;
      s0_dly_r <= dly_clamped;
    end
  end

  // Timer state, updated as an item moves into the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= dept_pkg::PH_NONE;
      last_phase_r <= dept_pkg::PH_NONE;
      level_r      <= 1'b0;
      since_on_r   <= '0;
      since_off_r  <= '0;
    end else if (advance) begin
      phase_r      <= res_nxt.phase;
      last_phase_r <= last_phase_nxt;
      level_r      <= res_nxt.level;
      since_on_r   <= since_on_nxt;
      since_off_r  <= since_off_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= s0_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_phase         = out_res_r.phase;
  assign out_output_level  = out_res_r.level;
  assign out_switched_on   = out_res_r.sw_on;
  assign out_switched_off  = out_res_r.sw_off;
  assign out_phase_changed = out_res_r.changed;

endmodule

`default_nettype wire

// ----- sv/dept_checker.sv -----
// Port-level checks for the delayed event pulse timer unit, bound to the top.
// Depends on dept_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none

`include "delayed_event_pulse_timer_unit_macros.svh"

module dept_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [2:0] out_phase,
  input wire logic       out_output_level,
  input wire logic       out_switched_on,
  input wire logic       out_switched_off,
  input wire logic       out_phase_changed
);

  // A stalled result holds until its transfer.
  `DEPT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_phase) && $stable(out_output_level) && $stable(out_phase_changed), "stalled result changed")

  // Switching on always leaves the output driven.
  `DEPT_ASSERT_NOW(a_on_level, out_valid && out_switched_on, out_output_level, "switched on with output low")

  // Switching off leaves the output low and cannot coincide with switching on.
  `DEPT_ASSERT_NOW(a_off_level, out_valid && out_switched_off, !out_output_level && !out_switched_on, "switched off inconsistent")

  // The output is only raised when entering or staying in the on or off phase.
  `DEPT_ASSERT_NOW(a_on_phase, out_valid && out_switched_on, (out_phase == dept_pkg::PH_ON) || (out_phase == dept_pkg::PH_OFF), "switched on outside on or off phase")

endmodule

bind delayed_event_pulse_timer_unit dept_checker u_dept_checker (.*);

`default_nettype wire

// ----- test/tb_delayed_event_pulse_timer_unit.sv -----
`timescale 1ns / 1ps
// Self-checking bench for delayed_event_pulse_timer_unit: directed commands, register extremes
// and random tick and command traffic under three idling profiles.
// Depends on dept_pkg and the unit itself; every status item is predicted inside the bench.

module tb_delayed_event_pulse_timer_unit;

  localparam logic [2:0]  CMD_SPARE_LO = 3'd6;
  localparam logic [2:0]  CMD_SPARE_HI = 3'd7;
  localparam logic [2:0]  REG_SPARE    = 3'd7;
  localparam logic [2:0]  TY_SPARE     = 3'd7;
  localparam logic [31:0] T_SAT        = 32'hFFFF_FFFF;
  localparam int          BLOCK_ITEMS  = 73;

  logic                         clk;
  logic                         rst_n          = 1'b0;
  logic                         in_valid       = 1'b0;
  logic                         in_ready;
  logic [2:0]                   in_command     = dept_pkg::CMD_TICK;
  logic [dept_pkg::FIELD_W-1:0] in_delay_value = '0;
  logic                         out_valid;
  logic                         out_ready      = 1'b0;
  logic [2:0]                   out_phase;
  logic                         out_output_level;
  logic                         out_switched_on;
  logic                         out_switched_off;
  logic                         out_phase_changed;
  logic                         cfg_valid      = 1'b0;
  logic                         cfg_ready;
  logic [2:0]                   cfg_index      = dept_pkg::REG_ON_DELAY;
  logic [dept_pkg::FIELD_W-1:0] cfg_data       = '0;

  int send_idle_pct = 21;
  int recv_idle_pct = 87;
  int err_count;
  int results_checked;
  int cmd_count [8];

  dept_pkg::res_t status_queue [$];

  // Predicted timer state.
  dept_pkg::phase_t m_phase;
  dept_pkg::phase_t m_reported;
  logic             m_level;
  logic             m_rise;
  logic             m_fall;
  logic [31:0]      m_on_cnt;
  logic [31:0]      m_off_cnt;
  logic [31:0]      m_on_dly;
  logic [31:0]      m_off_dly;
  logic [31:0]      m_pulse_hi;
  logic [31:0]      m_pulse_lo;
  logic [2:0]       m_mode;

  delayed_event_pulse_timer_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_delay_value   (in_delay_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_phase        (out_phase),
    .out_output_level (out_output_level),
    .out_switched_on  (out_switched_on),
    .out_switched_off (out_switched_off),
    .out_phase_changed(out_phase_changed),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void reset_model();
    m_phase    = dept_pkg::PH_NONE;
    m_reported = dept_pkg::PH_NONE;
    m_level    = 1'b0;
    m_on_cnt   = '0;
    m_off_cnt  = '0;
    m_on_dly   = '0;
    m_off_dly  = '0;
    m_pulse_hi = '0;
    m_pulse_lo = '0;
    m_mode     = dept_pkg::TY_NORMAL;
  endfunction

  function automatic void load_register(input logic [2:0] idx, input logic [31:0] v);
    case (idx)
      dept_pkg::REG_ON_DELAY:  m_on_dly   = v;
      dept_pkg::REG_OFF_DELAY: m_off_dly  = v;
      dept_pkg::REG_EV_TYPE:   m_mode     = v[2:0];
      dept_pkg::REG_PULSE_ON:  m_pulse_hi = v;
      dept_pkg::REG_PULSE_OFF: m_pulse_lo = v;
      default: ;
    endcase
  endfunction

  function automatic void raise_output();
    m_rise  = 1'b1;
    m_level = 1'b1;
  endfunction

  function automatic void drop_output();
    if (m_level) m_fall = 1'b1;
    m_level = 1'b0;
  endfunction

  // A repeated on or off is ignored once that phase is pending or reached.
  function automatic void begin_on();
    if (m_phase == dept_pkg::PH_WAIT_ON || m_phase == dept_pkg::PH_ON) return;
    m_on_cnt = '0;
    if (m_on_dly == '0) begin
      m_phase = dept_pkg::PH_ON;
      raise_output();
    end else begin
      m_phase = dept_pkg::PH_WAIT_ON;
    end
  endfunction

  function automatic void begin_off();
    if (m_phase == dept_pkg::PH_WAIT_OFF || m_phase == dept_pkg::PH_OFF) return;
    m_off_cnt = '0;
    if (m_off_dly == '0) begin
      m_phase = dept_pkg::PH_OFF;
      drop_output();
    end else begin
      m_phase = dept_pkg::PH_WAIT_OFF;
    end
  endfunction

  function automatic void tick_timer();
    logic pulsed;
    logic after_off;
    pulsed    = (m_mode == dept_pkg::TY_PULSE) || (m_mode == dept_pkg::TY_PULSE2) ||
                (m_mode == dept_pkg::TY_PWM);
    after_off = (m_mode == dept_pkg::TY_PULSE_OFF) || (m_mode == dept_pkg::TY_PULSE2);
    if (m_on_cnt != T_SAT) m_on_cnt = m_on_cnt + 1;
    if (m_off_cnt != T_SAT) m_off_cnt = m_off_cnt + 1;
    case (m_phase)
      dept_pkg::PH_WAIT_ON: begin
        if (m_on_cnt > m_on_dly) begin
          m_phase  = dept_pkg::PH_ON;
          m_on_cnt = '0;
          raise_output();
        end
      end
      dept_pkg::PH_WAIT_OFF: begin
        if (m_off_cnt > m_off_dly) begin
          m_phase   = dept_pkg::PH_OFF;
          m_off_cnt = '0;
          drop_output();
        end
      end
      dept_pkg::PH_ON: begin
        if (pulsed && m_level && m_on_cnt > m_pulse_hi) begin
          m_on_cnt = '0;
          drop_output();
        end else if (m_mode == dept_pkg::TY_PWM && !m_level && m_on_cnt > m_pulse_lo) begin
          m_on_cnt = '0;
          raise_output();
        end
      end
      dept_pkg::PH_OFF: begin
        // The after-off pulse keeps repeating while the phase stays off.
        if (after_off && !m_level) begin
          m_on_cnt = '0;
          raise_output();
        end else if (after_off && m_level && m_on_cnt > m_pulse_hi) begin
          m_on_cnt = '0;
          drop_output();
        end
      end
      default: ;
    endcase
  endfunction

  function automatic dept_pkg::res_t advance_timer(input logic [2:0] cmd,
                                                   input logic [31:0] dv);
    dept_pkg::res_t st;
    logic           changed;
    changed = 1'b0;
    m_rise  = 1'b0;
    m_fall  = 1'b0;
    case (cmd)
      dept_pkg::CMD_TICK: begin
        tick_timer();
        if (m_phase != m_reported) begin
          changed    = 1'b1;
          m_reported = m_phase;
        end
      end
      dept_pkg::CMD_ON:        begin_on();
      dept_pkg::CMD_OFF:       begin_off();
      dept_pkg::CMD_CLR_PHASE: m_phase = dept_pkg::PH_NONE;
      dept_pkg::CMD_ON_DELAY: begin
        m_on_dly = dv;
        begin_on();
      end
      dept_pkg::CMD_OFF_DELAY: begin
        m_off_dly = dv;
        begin_off();
      end
      default: ;
    endcase
    st.phase   = m_phase;
    st.level   = m_level;
    st.sw_on   = m_rise;
    st.sw_off  = m_fall;
    st.changed = changed;
    return st;
  endfunction

  // Mostly short spans so that delays expire, with the odd saturated or wide value.
  function automatic logic [31:0] pick_ticks();
    int r;
    r = $urandom_range(23);
    if (r == 0) return T_SAT;
    if (r == 1) return $urandom();
    return $urandom_range(5);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want_v,
                                      input logic [31:0] got_v);
    if (want_v !== got_v) begin
      err_count++;
      $display("%0t: %s expected %0d actual %0d", $time, name, want_v, got_v);
    end
  endfunction

  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk) begin : check_status
    dept_pkg::res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (status_queue.size() == 0) begin
        err_count++;
        $display("%0t: status expected none actual phase %0d", $time, out_phase);
      end else begin
        want = status_queue.pop_front();
        check_field("phase", want.phase, out_phase);
        check_field("output_level", want.level, out_output_level);
        check_field("switched_on", want.sw_on, out_switched_on);
        check_field("switched_off", want.sw_off, out_switched_off);
        check_field("phase_changed", want.changed, out_phase_changed);
        results_checked++;
      end
    end
  end

  // Valid stays high between back-to-back items and drops only for a gap.
  task automatic issue_item(input logic [2:0] cmd, input logic [31:0] dv);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid       <= 1'b1;
    in_command     <= cmd;
    in_delay_value <= dv;
    do @(posedge clk); while (!in_ready);
    status_queue.push_back(advance_timer(cmd, dv));
    cmd_count[cmd]++;
  endtask

  task automatic issue_ticks(input int count);
    repeat (count) issue_item(dept_pkg::CMD_TICK, $urandom());
  endtask

  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (status_queue.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes every register back to back; the spare index must change nothing.
  task automatic program_regs(input logic [31:0] on_d, input logic [31:0] off_d,
                              input logic [2:0] ev, input logic [31:0] hi,
                              input logic [31:0] lo);
    logic [2:0]  idx [6];
    logic [31:0] val [6];
    idx[0] = dept_pkg::REG_ON_DELAY;
    idx[1] = dept_pkg::REG_OFF_DELAY;
    idx[2] = dept_pkg::REG_EV_TYPE;
    idx[3] = dept_pkg::REG_PULSE_ON;
    idx[4] = dept_pkg::REG_PULSE_OFF;
    idx[5] = REG_SPARE;
    val[0] = on_d;
    val[1] = off_d;
    val[2] = $urandom();
    val[2][2:0] = ev;
    val[3] = hi;
    val[4] = lo;
    val[5] = $urandom();
    cfg_valid <= 1'b1;
    for (int i = 0; i < 6; i++) begin
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      do @(posedge clk); while (!cfg_ready);
      load_register(idx[i], val[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic test_directed_commands();
    issue_item(dept_pkg::CMD_TICK, T_SAT);
    issue_item(dept_pkg::CMD_ON, '0);
    issue_item(dept_pkg::CMD_ON, $urandom());
    issue_item(dept_pkg::CMD_TICK, '0);
    issue_item(dept_pkg::CMD_OFF, $urandom());
    issue_item(dept_pkg::CMD_OFF, T_SAT);
    issue_item(CMD_SPARE_LO, T_SAT);
    issue_item(CMD_SPARE_HI, '0);
    issue_item(dept_pkg::CMD_CLR_PHASE, $urandom());
    issue_item(dept_pkg::CMD_TICK, $urandom());
    issue_item(dept_pkg::CMD_ON_DELAY, 32'd2);
    issue_item(dept_pkg::CMD_ON, $urandom());
    issue_ticks(3);
    // Ignored while on, but the new delay still replaces the old one.
    issue_item(dept_pkg::CMD_ON_DELAY, T_SAT);
    issue_item(dept_pkg::CMD_OFF_DELAY, 32'd1);
    issue_ticks(2);
    issue_item(dept_pkg::CMD_ON_DELAY, T_SAT);
    issue_item(dept_pkg::CMD_TICK, $urandom());
    issue_item(dept_pkg::CMD_OFF_DELAY, '0);
    issue_item(dept_pkg::CMD_CLR_PHASE, '0);
    issue_item(dept_pkg::CMD_ON_DELAY, '0);
    issue_item(dept_pkg::CMD_TICK, $urandom());
    drain_pipeline();
  endtask

  task automatic test_register_extremes();
    program_regs(T_SAT, T_SAT, TY_SPARE, T_SAT, T_SAT);
    issue_item(dept_pkg::CMD_ON, $urandom());
    issue_ticks(3);
    issue_item(dept_pkg::CMD_OFF, $urandom());
    issue_ticks(2);
    issue_item(dept_pkg::CMD_CLR_PHASE, $urandom());
    issue_ticks(1);
    drain_pipeline();
    program_regs('0, '0, dept_pkg::TY_PULSE2, '0, '0);
    issue_item(dept_pkg::CMD_ON, $urandom());
    issue_ticks(4);
    issue_item(dept_pkg::CMD_OFF, $urandom());
    issue_ticks(4);
    drain_pipeline();
    program_regs('0, '0, dept_pkg::TY_PWM, '0, '0);
    issue_item(dept_pkg::CMD_ON, $urandom());
    issue_ticks(4);
    issue_item(dept_pkg::CMD_OFF, $urandom());
    issue_ticks(2);
    drain_pipeline();
  endtask

  task automatic test_random_traffic(input int s_pct, input int r_pct);
    logic [2:0]  cmd;
    logic [31:0] dv;
    int          pick;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int m = 0; m < 8; m++) begin
      drain_pipeline();
      program_regs(pick_ticks(), pick_ticks(), 3'(m), pick_ticks(), pick_ticks());
      for (int n = 0; n < BLOCK_ITEMS; n++) begin
        pick = $urandom_range(99);
        dv   = $urandom();
        if (pick < 64) begin
          cmd = dept_pkg::CMD_TICK;
        end else if (pick < 74) begin
          cmd = dept_pkg::CMD_ON;
        end else if (pick < 84) begin
          cmd = dept_pkg::CMD_OFF;
        end else if (pick < 88) begin
          cmd = dept_pkg::CMD_CLR_PHASE;
        end else if (pick < 93) begin
          cmd = dept_pkg::CMD_ON_DELAY;
          dv  = pick_ticks();
        end else if (pick < 98) begin
          cmd = dept_pkg::CMD_OFF_DELAY;
          dv  = pick_ticks();
        end else begin
          cmd = $urandom_range(1) ? CMD_SPARE_HI : CMD_SPARE_LO;
        end
        issue_item(cmd, dv);
        // Let the pipeline run dry once in the middle of a block.
        if (m == 3 && n == BLOCK_ITEMS / 2) drain_pipeline();
      end
    end
    drain_pipeline();
  endtask

  initial begin
    reset_model();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_commands();
    test_register_extremes();
    test_random_traffic(21, 87);
    test_random_traffic(87, 21);
    test_random_traffic(0, 0);
    repeat (8) @(posedge clk);
    if (status_queue.size() != 0) begin
      err_count++;
      $display("%0t: %0d status items expected but never received", $time,
               status_queue.size());
    end
    $display("Covered %0d ticks, %0d on, %0d off, %0d phase clears, %0d spare codes;",
             cmd_count[dept_pkg::CMD_TICK],
             cmd_count[dept_pkg::CMD_ON] + cmd_count[dept_pkg::CMD_ON_DELAY],
             cmd_count[dept_pkg::CMD_OFF] + cmd_count[dept_pkg::CMD_OFF_DELAY],
             cmd_count[dept_pkg::CMD_CLR_PHASE],
             cmd_count[CMD_SPARE_LO] + cmd_count[CMD_SPARE_HI]);
    $display("all event types, register extremes, three idling profiles, %0d statuses compared.",
             results_checked);
    if (err_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #(10_000_000);
    $display("Timed out with %0d status items outstanding", status_queue.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+sv
sv/dept_pkg.sv
sv/dept_clamp.sv
sv/dept_cfg.sv
sv/dept_step.sv
sv/delayed_event_pulse_timer_unit.sv
sv/dept_checker.sv
test/tb_delayed_event_pulse_timer_unit.sv
